FILE: rtl/rfic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfic_pkg
// Shared types, constants and the crc byte update for the radio frame
// integrity check.
// ----------------------------------------------------------------------------
package rfic_pkg;

   // position of the length byte in the frame, counted from zero (2 .. 15)
   localparam int LENGTH_OFFSET = 7;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 8;
   localparam int CRC_W     = 16;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_FIELD_W = 11;

   // head store index width
   localparam int HEAD_IDX_W = (LENGTH_OFFSET > 1) ? $clog2(LENGTH_OFFSET) : 1;

   // queue between front and back end, power of two
   localparam int QUEUE_DEPTH = 2;

   // check value seeds
   localparam logic [BYTE_W-1:0] XOR_SEED = 8'hFF;
   localparam logic [CRC_W-1:0]  CRC_SEED = 16'h1D0F;

   // count saturation
   localparam logic [POS_W-1:0] POS_MAX = 8'hFF;

   // register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHECK_MODE   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SIZE_XOR = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SIZE_CRC = 2'd2;

   localparam logic [BYTE_W-1:0] MIN_SIZE_XOR_RST = 8'd10;
   localparam logic [BYTE_W-1:0] MIN_SIZE_CRC_RST = 8'd12;

   // check mode codes
   localparam logic MODE_XOR = 1'b0;
   localparam logic MODE_CRC = 1'b1;

   // one classified byte on its way from front to back end
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
      logic [POS_W-1:0]  pos;
   } q_entry_type;

   // crc-16 byte update, polynomial 0x1021, msb first
   function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] x;
      x = {8'h00, crc[15:8] ^ b};
      x = x ^ (x >> 4);
      return (crc << 8) ^ (x << 12) ^ (x << 5) ^ x;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rfic_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfic_queue
// Short first-in first-out queue decoupling the byte front end from the
// check back end.
// ----------------------------------------------------------------------------
module rfic_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire rfic_pkg::q_entry_type push_data,
   output logic                      full,
   input  wire logic                 pop,
   output logic                      pop_valid,
   output rfic_pkg::q_entry_type     pop_data
);
   import rfic_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   q_entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/rfic_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfic_front
// Accepts frame bytes, tags each with its saturating position in the frame
// and hands it to the queue.
// ----------------------------------------------------------------------------
module rfic_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [rfic_pkg::REQ_DATA_W-1:0] req_tdata,  // byte_value
   input  wire logic                  req_tlast,            // last_byte
   input  wire logic                  queue_full,
   output logic                       push,
   output rfic_pkg::q_entry_type      push_data
);
   import rfic_pkg::*;

   logic [POS_W-1:0] count_ff, count_in;

   assign req_tready = !queue_full;
   assign push       = req_tvalid && req_tready;

   // classify the transaction
   always_comb begin
      push_data.byte_value = req_tdata[BYTE_W-1:0];
      push_data.last_byte  = req_tlast;
      push_data.pos        = count_ff;
   end

   // position counter, saturates, restarts after the last byte
   always_comb begin
      count_in = count_ff;
      if (push) begin
         if (req_tlast) begin
            count_in = '0;
         end else if (count_ff != POS_MAX) begin
            count_in = count_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/rfic_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfic_back
// Runs the xor checksum and crc over each queued byte, resolves the bytes
// ahead of the length field once it arrives, and issues the verdict.
// ----------------------------------------------------------------------------
module rfic_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire rfic_pkg::q_entry_type q_data,
   output logic                       q_pop,
   input  wire logic                  csr_we,
   input  wire logic [rfic_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [rfic_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [rfic_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import rfic_pkg::*;

   localparam logic [POS_W-1:0] LEN_POS = POS_W'(LENGTH_OFFSET);

   // configuration
   logic              mode_ff;
   logic [BYTE_W-1:0] min_xor_ff;
   logic [BYTE_W-1:0] min_crc_ff;

   // frame state
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0] th_ff, th_in;
   logic [BYTE_W-1:0] tl_ff, tl_in;

   // bytes ahead of the length field and the check prefixes before each
   logic [BYTE_W-1:0] head_byte_ff [LENGTH_OFFSET];
   logic [BYTE_W-1:0] head_xor_ff  [LENGTH_OFFSET];
   logic [CRC_W-1:0]  head_crc_ff  [LENGTH_OFFSET];

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_FIELD_W-1:0] rsp_data_ff, rsp_data_in;

   // working values
   logic [BYTE_W-1:0] b;
   logic [POS_W-1:0]  p;
   logic [POS_W:0]    p9, l9;
   logic [BYTE_W-1:0] upd_len, upd_xor, upd_th, upd_tl;
   logic [CRC_W-1:0]  upd_crc, crc_step;
   logic [BYTE_W-1:0] size, min_size;
   logic              size_ok, match, check_ok;
   logic              head_we;

   assign b        = q_data.byte_value;
   assign p        = q_data.pos;
   assign p9       = {1'b0, p};
   assign crc_step = crc_update(crc_ff, b);
   assign q_pop    = q_valid && (!q_data.last_byte || !rsp_valid_ff || rsp_tready);
   assign head_we  = q_pop && (p < LEN_POS);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_XOR;
         min_xor_ff <= MIN_SIZE_XOR_RST;
         min_crc_ff <= MIN_SIZE_CRC_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CHECK_MODE:   mode_ff    <= csr_wdata[0];
            CSR_MIN_SIZE_XOR: min_xor_ff <= csr_wdata[BYTE_W-1:0];
            CSR_MIN_SIZE_CRC: min_crc_ff <= csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // fold the byte into the check values
   always_comb begin
      upd_len = len_ff;
      upd_xor = xor_ff;
      upd_crc = crc_ff;
      upd_th  = th_ff;
      upd_tl  = tl_ff;
      l9      = {1'b0, b};
      if (p < LEN_POS) begin
         // length unknown yet: keep running prefixes over the head
         upd_xor = xor_ff ^ b;
         upd_crc = crc_step;
      end else if (p == LEN_POS) begin
         // length byte: pick the prefixes and trailer that the length implies
         upd_len = b;
         upd_xor = xor_ff ^ b;
         upd_crc = crc_step;
         upd_th  = '0;
         upd_tl  = '0;
         for (int k = 0; k < LENGTH_OFFSET; k++) begin
            if (l9 == (POS_W+1)'(k + 1) || (k == 0 && l9 == '0)) begin
               upd_xor = head_xor_ff[k];
            end
            if (l9 == (POS_W+1)'(k + 2) || (k == 0 && l9 < (POS_W+1)'(2))) begin
               upd_crc = head_crc_ff[k];
            end
            if (l9 == (POS_W+1)'(k + 2)) begin
               upd_th = head_byte_ff[k];
            end
            if (l9 == (POS_W+1)'(k + 1)) begin
               upd_tl = head_byte_ff[k];
            end
         end
         if (l9 == (POS_W+1)'(LENGTH_OFFSET + 1)) begin
            upd_xor = xor_ff;
            upd_tl  = b;
         end
         if (l9 == (POS_W+1)'(LENGTH_OFFSET + 2)) begin
            upd_crc = crc_ff;
            upd_th  = b;
         end
      end else begin
         // past the length byte: plain range checks
         if (p9 + (POS_W+1)'(1) < {1'b0, len_ff}) begin
            upd_xor = xor_ff ^ b;
         end
         if (p9 + (POS_W+1)'(2) < {1'b0, len_ff}) begin
            upd_crc = crc_step;
         end
         if (p9 + (POS_W+1)'(2) == {1'b0, len_ff}) begin
            upd_th = b;
         end
         if (p9 + (POS_W+1)'(1) == {1'b0, len_ff}) begin
            upd_tl = b;
         end
      end
   end

   // verdict on the last byte
   always_comb begin
      size     = (p == POS_MAX) ? POS_MAX : p + POS_W'(1);
      min_size = (mode_ff == MODE_CRC) ? min_crc_ff : min_xor_ff;
      size_ok  = (size >= min_size) && (upd_len <= size) && (upd_len >= min_size);
      if (mode_ff == MODE_CRC) begin
         match = (upd_len >= BYTE_W'(2)) && (upd_crc == {upd_th, upd_tl});
      end else begin
         match = (upd_len >= BYTE_W'(1)) && (upd_xor == upd_tl);
      end
      check_ok = size_ok && match;
   end

   // next frame state and output register
   always_comb begin
      len_in       = len_ff;
      xor_in       = xor_ff;
      crc_in       = crc_ff;
      th_in        = th_ff;
      tl_in        = tl_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (q_pop) begin
         if (q_data.last_byte) begin
            len_in       = '0;
            xor_in       = XOR_SEED;
            crc_in       = CRC_SEED;
            th_in        = '0;
            tl_in        = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {upd_len, check_ok, size_ok, size_ok && check_ok};
         end else begin
            len_in = upd_len;
            xor_in = upd_xor;
            crc_in = upd_crc;
            th_in  = upd_th;
            tl_in  = upd_tl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         xor_ff       <= XOR_SEED;
         crc_ff       <= CRC_SEED;
         th_ff        <= '0;
         tl_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         xor_ff       <= xor_in;
         crc_ff       <= crc_in;
         th_ff        <= th_in;
         tl_ff        <= tl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (head_we) begin
         head_byte_ff[p[HEAD_IDX_W-1:0]] <= b;
         head_xor_ff[p[HEAD_IDX_W-1:0]]  <= xor_ff;
         head_crc_ff[p[HEAD_IDX_W-1:0]]  <= crc_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-RSP_FIELD_W)'(0), rsp_data_ff};

endmodule
`default_nettype wire

FILE: rtl/radio_frame_integrity_check.sv
// A verdict reaches rsp through the queue and then the output register; the
// last byte stays queued while an earlier verdict holds the output register.
// Throughput: one byte per cycle while the queue is not full; queue and output
// register let the front take more bytes while a verdict waits on rsp_tready.
// The crc and xor update of one byte in the back end sets the per-cycle work.
// Reset: synchronous, clears the position counter, queue, frame state and
// output valid, and returns the registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// radio_frame_integrity_check
// Checks size, length field and xor checksum or crc-16 trailer of received
// radio frames streamed one byte per transaction.
// ----------------------------------------------------------------------------
module radio_frame_integrity_check (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [rfic_pkg::REQ_DATA_W-1:0] req_tdata,  // byte_value
   input  wire logic        req_tlast,                      // last_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // frame_good, size_good, check_good, frame_length[7:0], zero fill
   output logic [rfic_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [rfic_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [rfic_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rfic_pkg::*;

   q_entry_type push_data, pop_data;
   logic        push, queue_full, pop, pop_valid;

   // front end
   rfic_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // decoupling queue
   rfic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   // back end
   rfic_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_data     (pop_data),
      .q_pop      (pop),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

FILE: rtl/rfic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfic_checker
// Port-level checks on the verdict stream of the frame integrity check.
// ----------------------------------------------------------------------------
module rfic_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // a stalled verdict holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // frame good is size good and check good together
   a_good_and: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[0] == (rsp_tdata[1] && rsp_tdata[2]))
      else $error("frame_good does not match size_good and check_good");

   // check good is forced low when the size fails
   a_check_needs_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1])
      else $error("check_good set with size_good clear");

   // a matching trailer needs a non-zero length field
   a_check_needs_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[10:3] != 8'd0)
      else $error("check_good set with zero frame_length");

   // no verdict straight out of reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind radio_frame_integrity_check rfic_checker u_rfic_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
